/* design/tvi_pkg.sv */
// Shared types and constants of the trilinear volume interpolator.
// Used by tvi_coord, tvi_blend, the top level and the testbench; depends on nothing.
`default_nettype none
package tvi_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_INV_X    = 3'd3,
        CFG_INV_Y    = 3'd4,
        CFG_INV_Z    = 3'd5
    } t_cfg_idx;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  ix;
        logic [3:0]  iy;
        logic [3:0]  iz;
        logic [31:0] value;
    } t_wr_item;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_coord_en;

    typedef struct packed {
        logic x_mul;
        logic y_mul;
        logic y_sum;
        logic z_mul;
        logic z_sum;
    } t_blend_en;

endpackage
`default_nettype wire

/* design/tvi_bank.sv */
// One parity bank of the sample store: one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module tvi_bank #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/tvi_coord.sv */
// Three-stage axis mapper: offset, scale by inverse spacing, clamp into cell and weight.
// Depends on tvi_pkg.
`default_nettype none
module tvi_coord #(
    parameter int POINTS = 16,
    parameter int CW     = 4
) (
    input  wire logic                 i_clk,
    input  wire tvi_pkg::t_coord_en   i_en,
    input  wire logic signed [31:0]   i_pos,
    input  wire logic signed [31:0]   i_org,
    input  wire logic        [31:0]   i_inv,
    output logic             [CW-1:0] o_cell,
    output logic             [16:0]   o_weight
);

    localparam logic [47:0]   MAXC = 48'(POINTS - 1) << 16;
    localparam logic [CW-1:0] LAST = CW'(POINTS - 2);

    logic signed [32:0] r_d;
    logic               r_pos;
    logic        [63:0] r_prod;
    logic      [CW-1:0] r_cell;
    logic        [16:0] r_w;
    logic        [47:0] n_c;
    logic      [CW-1:0] n_hi;
    logic               n_lim;

    always_comb begin
        n_c = r_prod[63:16];
        if (!r_pos) begin
            n_c = '0;
        end else if (n_c > MAXC) begin
            n_c = MAXC;
        end
        n_hi  = n_c[16 +: CW];
        n_lim = n_hi > LAST;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_d <= $signed({i_pos[31], i_pos}) - $signed({i_org[31], i_org});
        end
        if (i_en.s2) begin
            r_pos  <= !r_d[32] && (r_d != '0);
            r_prod <= r_d[31:0] * i_inv;
        end
        if (i_en.s3) begin
            r_cell <= n_lim ? LAST : n_hi;
            r_w    <= n_lim ? 17'h1_0000 : {1'b0, n_c[15:0]};
        end
    end

    assign o_cell   = r_cell;
    assign o_weight = r_w;

endmodule
`default_nettype wire

/* design/tvi_blend.sv */
// Five-stage corner blend: x lerp, y product, y round, z product, z round and saturate.
// Depends on tvi_pkg.
`default_nettype none
module tvi_blend (
    input  wire logic               i_clk,
    input  wire tvi_pkg::t_blend_en i_en,
    input  wire logic        [31:0] i_bank [8],
    input  wire logic        [2:0]  i_par,
    input  wire logic        [16:0] i_wx,
    input  wire logic        [16:0] i_wy,
    input  wire logic        [16:0] i_wz,
    output logic signed      [31:0] o_value
);

    logic signed [50:0] r_cx [4];
    logic        [16:0] r6_wy;
    logic        [16:0] r6_wz;
    logic signed [50:0] r7_c [2];
    logic signed [69:0] r7_p [2];
    logic        [16:0] r7_wz;
    logic signed [53:0] r8_c [2];
    logic        [16:0] r8_wz;
    logic signed [53:0] r9_c0;
    logic signed [72:0] r9_p;
    logic signed [31:0] r_out;

    logic signed [50:0] n_cx [4];
    logic signed [69:0] n_py [2];
    logic signed [53:0] n_c  [2];
    logic signed [72:0] n_pz;
    logic signed [31:0] n_out;

    always_comb begin
        logic        [2:0]  ca;
        logic        [2:0]  cb;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [32:0] dx;
        logic signed [50:0] px;
        logic signed [51:0] dy;
        logic signed [69:0] sy;
        logic signed [69:0] ty;
        logic signed [54:0] dz;
        logic signed [73:0] sz;
        logic signed [41:0] rz;
        for (int k = 0; k < 4; k++) begin
            ca = {2'(k), 1'b0} ^ i_par;
            cb = {2'(k), 1'b1} ^ i_par;
            lo = i_bank[ca];
            hi = i_bank[cb];
            dx = $signed({hi[31], hi}) - $signed({lo[31], lo});
            px = dx * $signed({1'b0, i_wx});
            n_cx[k] = (51'(lo) <<< 16) + px;
        end
        for (int j = 0; j < 2; j++) begin
            dy = 52'(r_cx[2*j+1]) - 52'(r_cx[2*j]);
            n_py[j] = dy * $signed({1'b0, r6_wy});
            sy = (70'(r7_c[j]) <<< 16) + r7_p[j];
            ty = sy + 70'sd32768;
            n_c[j] = ty[69:16];
        end
        dz   = 55'(r8_c[1]) - 55'(r8_c[0]);
        n_pz = dz * $signed({1'b0, r8_wz});
        sz   = (74'(r9_c0) <<< 16) + 74'(r9_p) + 74'sd2147483648;
        rz   = sz[73:32];
        if (rz > 42'sd2147483647) begin
            n_out = 32'h7FFF_FFFF;
        end else if (rz < -42'sd2147483648) begin
            n_out = 32'h8000_0000;
        end else begin
            n_out = rz[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.x_mul) begin
            r_cx  <= n_cx;
            r6_wy <= i_wy;
            r6_wz <= i_wz;
        end
        if (i_en.y_mul) begin
            r7_c[0] <= r_cx[0];
            r7_c[1] <= r_cx[2];
            r7_p    <= n_py;
            r7_wz   <= r6_wz;
        end
        if (i_en.y_sum) begin
            r8_c  <= n_c;
            r8_wz <= r7_wz;
        end
        if (i_en.z_mul) begin
            r9_c0 <= r8_c[0];
            r9_p  <= n_pz;
        end
        if (i_en.z_sum) begin
            r_out <= n_out;
        end
    end

    assign o_value = r_out;

endmodule
`default_nettype wire

/* design/trilinear_volume_interpolator_top.sv */
// Top level of the trilinear volume interpolator: registers, stage control, store banks.
// Depends on tvi_pkg, tvi_coord, tvi_bank and tvi_blend.
//
//   channel  | direction | handshake           | payload
//   input    | in        | i_valid / o_stall   | i_command, i_write_*, i_pos_*
//   output   | out       | o_valid / i_stall   | o_interp_value
//   config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// Ten register stages; a query result leaves from the last. One item is taken per cycle
// while o_stall is low; the eight parity banks give all cell corners in one read.
// Each stage holds its item only while the stage after it is full and held, so a
// stall at the output fills empty stages first. Reset clears only valid bits and the
// configuration registers; the store has no clearing pass.
`default_nettype none
module trilinear_volume_interpolator_top #(
    parameter int POINTS_X = 16,
    parameter int POINTS_Y = 16,
    parameter int POINTS_Z = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [3:0]  i_write_ix,
    input  wire logic [3:0]  i_write_iy,
    input  wire logic [3:0]  i_write_iz,
    input  wire logic [31:0] i_write_value,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_interp_value,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int XW = $clog2(POINTS_X);
    localparam int YW = $clog2(POINTS_Y);
    localparam int ZW = $clog2(POINTS_Z);
    localparam int HX = (POINTS_X + 1) / 2;
    localparam int HY = (POINTS_Y + 1) / 2;
    localparam int HZ = (POINTS_Z + 1) / 2;
    localparam int BD = HX * HY * HZ;
    localparam int AW = (BD > 1) ? $clog2(BD) : 1;

    logic [31:0] r_origin_x;
    logic [31:0] r_origin_y;
    logic [31:0] r_origin_z;
    logic [31:0] r_inv_x;
    logic [31:0] r_inv_y;
    logic [31:0] r_inv_z;

    logic [10:1] r_v;
    logic [10:1] rdy;

    tvi_pkg::t_wr_item r1_item;
    tvi_pkg::t_wr_item r2_item;
    tvi_pkg::t_wr_item r3_item;
    tvi_pkg::t_coord_en coord_en;
    tvi_pkg::t_blend_en blend_en;

    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [ZW-1:0] cz;
    logic [16:0]   wx;
    logic [16:0]   wy;
    logic [16:0]   wz;

    logic [AW-1:0] r4_raddr [8];
    logic [AW-1:0] r4_waddr;
    logic [2:0]    r4_wbank;
    logic          r4_we;
    logic [31:0]   r4_wdata;
    logic          r4_cmd;
    logic [2:0]    r4_par;
    logic [16:0]   r4_wx;
    logic [16:0]   r4_wy;
    logic [16:0]   r4_wz;
    logic [2:0]    r5_par;
    logic [16:0]   r5_wx;
    logic [16:0]   r5_wy;
    logic [16:0]   r5_wz;

    logic [AW-1:0] n_raddr [8];
    logic [AW-1:0] n_waddr;
    logic          n_we;
    logic [7:0]    bank_we;
    logic [31:0]   bank_q [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_inv_x    <= tvi_pkg::ONE_Q16;
            r_inv_y    <= tvi_pkg::ONE_Q16;
            r_inv_z    <= tvi_pkg::ONE_Q16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tvi_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                tvi_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                tvi_pkg::CFG_ORIGIN_Z: r_origin_z <= i_cfg_data;
                tvi_pkg::CFG_INV_X:    r_inv_x    <= i_cfg_data;
                tvi_pkg::CFG_INV_Y:    r_inv_y    <= i_cfg_data;
                tvi_pkg::CFG_INV_Z:    r_inv_z    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rdy[10] = !r_v[10] || !i_stall;
        for (int k = 9; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign coord_en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3]};
    assign blend_en = '{x_mul: rdy[6], y_mul: rdy[7], y_sum: rdy[8],
                        z_mul: rdy[9], z_sum: rdy[10]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 10; k >= 2; k--) begin
                if (rdy[k]) begin
                    if (k == 5) begin
                        r_v[k] <= r_v[k-1] && (r4_cmd == tvi_pkg::CMD_QUERY);
                    end else begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
            if (rdy[1]) begin
                r_v[1] <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_item <= '{cmd: i_command, ix: i_write_ix, iy: i_write_iy,
                         iz: i_write_iz, value: i_write_value};
        end
        if (rdy[2]) begin
            r2_item <= r1_item;
        end
        if (rdy[3]) begin
            r3_item <= r2_item;
        end
    end

    tvi_coord #(.POINTS(POINTS_X), .CW(XW)) u_coord_x (
        .i_clk(i_clk), .i_en(coord_en), .i_pos(i_pos_x), .i_org(r_origin_x),
        .i_inv(r_inv_x), .o_cell(cx), .o_weight(wx)
    );

    tvi_coord #(.POINTS(POINTS_Y), .CW(YW)) u_coord_y (
        .i_clk(i_clk), .i_en(coord_en), .i_pos(i_pos_y), .i_org(r_origin_y),
        .i_inv(r_inv_y), .o_cell(cy), .o_weight(wy)
    );

    tvi_coord #(.POINTS(POINTS_Z), .CW(ZW)) u_coord_z (
        .i_clk(i_clk), .i_en(coord_en), .i_pos(i_pos_z), .i_org(r_origin_z),
        .i_inv(r_inv_z), .o_cell(cz), .o_weight(wz)
    );

    always_comb begin
        logic [2:0]  bb;
        logic [31:0] xi;
        logic [31:0] yi;
        logic [31:0] zi;
        logic [31:0] lin;
        for (int b = 0; b < 8; b++) begin
            bb  = 3'(b);
            xi  = (cx[0] == bb[0]) ? 32'(cx) : 32'(cx) + 32'd1;
            yi  = (cy[0] == bb[1]) ? 32'(cy) : 32'(cy) + 32'd1;
            zi  = (cz[0] == bb[2]) ? 32'(cz) : 32'(cz) + 32'd1;
            lin = (xi >> 1) + 32'(HX) * ((yi >> 1) + 32'(HY) * (zi >> 1));
            n_raddr[b] = lin[AW-1:0];
        end
        lin = (32'(r3_item.ix) >> 1)
            + 32'(HX) * ((32'(r3_item.iy) >> 1) + 32'(HY) * (32'(r3_item.iz) >> 1));
        n_waddr = lin[AW-1:0];
        n_we = (r3_item.cmd == tvi_pkg::CMD_WRITE)
            && (32'(r3_item.ix) < 32'(POINTS_X))
            && (32'(r3_item.iy) < 32'(POINTS_Y))
            && (32'(r3_item.iz) < 32'(POINTS_Z));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_raddr <= n_raddr;
            r4_waddr <= n_waddr;
            r4_wbank <= {r3_item.iz[0], r3_item.iy[0], r3_item.ix[0]};
            r4_we    <= n_we;
            r4_wdata <= r3_item.value;
            r4_cmd   <= r3_item.cmd;
            r4_par   <= {cz[0], cy[0], cx[0]};
            r4_wx    <= wx;
            r4_wy    <= wy;
            r4_wz    <= wz;
        end
        if (rdy[5]) begin
            r5_par <= r4_par;
            r5_wx  <= r4_wx;
            r5_wy  <= r4_wy;
            r5_wz  <= r4_wz;
        end
    end

    for (genvar g = 0; g < 8; g++) begin : g_bank
        assign bank_we[g] = rdy[5] && r_v[4] && r4_we && (r4_wbank == 3'(g));
        tvi_bank #(.DEPTH(BD), .AW(AW)) u_bank (
            .i_clk(i_clk), .i_we(bank_we[g]), .i_waddr(r4_waddr), .i_wdata(r4_wdata),
            .i_re(rdy[5]), .i_raddr(r4_raddr[g]), .o_rdata(bank_q[g])
        );
    end

    tvi_blend u_blend (
        .i_clk(i_clk), .i_en(blend_en), .i_bank(bank_q), .i_par(r5_par),
        .i_wx(r5_wx), .i_wy(r5_wy), .i_wz(r5_wz), .o_value(o_interp_value)
    );

    assign o_stall = !rdy[1];
    assign o_valid = r_v[10];

    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(bank_we) <= 1)
        else $error("more than one store bank written in a cycle");

    a_write_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rdy[5] && r_v[4] && r4_cmd == tvi_pkg::CMD_WRITE) |=> !r_v[5])
        else $error("write item went past the store stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v[1] && r_v[10] && i_stall))
        else $error("input stalled while the pipeline has room");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> (r5_wx <= 17'h1_0000 && r5_wy <= 17'h1_0000 && r5_wz <= 17'h1_0000))
        else $error("cell weight above one");

endmodule
`default_nettype wire

/* tb/sv/trilinear_volume_interpolator_top_tb.sv */
// Self-checking testbench of trilinear_volume_interpolator_top: random writes and queries
// under random valid and stall gaps, checked against an in-bench interpolation predictor.
// Depends on tvi_pkg and the trilinear_volume_interpolator_top design files.
`timescale 1ns / 1ps
module trilinear_volume_interpolator_top_tb;

    localparam int NPTS = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 14;
    localparam int PHASE_ITEMS = 210;

    class interp_scoreboard;
        logic [31:0] org [3];
        logic [31:0] inv [3];
        logic [31:0] grid [NPTS*NPTS*NPTS];
        logic [31:0] expected_values [$];
        int errors;

        function new();
            for (int a = 0; a < 3; a++) begin
                org[a] = '0;
                inv[a] = tvi_pkg::ONE_Q16;
            end
            errors = 0;
        endfunction

        function void set_reg(tvi_pkg::t_cfg_idx idx, logic [31:0] v);
            case (idx)
                tvi_pkg::CFG_ORIGIN_X: org[0] = v;
                tvi_pkg::CFG_ORIGIN_Y: org[1] = v;
                tvi_pkg::CFG_ORIGIN_Z: org[2] = v;
                tvi_pkg::CFG_INV_X:    inv[0] = v;
                tvi_pkg::CFG_INV_Y:    inv[1] = v;
                tvi_pkg::CFG_INV_Z:    inv[2] = v;
                default: ;
            endcase
        endfunction

        function void grid_coord(int a, logic [31:0] pos, output int cidx, output longint w);
            logic signed [33:0] d;
            logic [63:0] c;
            d = $signed({pos[31], pos[31], pos}) - $signed({org[a][31], org[a][31], org[a]});
            c = '0;
            if (d > 0) begin
                c = ({31'b0, d[32:0]} * {32'b0, inv[a]}) >> 16;
                if (c > (64'(NPTS - 1) << 16))
                    c = 64'(NPTS - 1) << 16;
            end
            cidx = int'(c >> 16);
            if (cidx > NPTS - 2)
                cidx = NPTS - 2;
            w = longint'(c) - (longint'(cidx) << 16);
        endfunction

        function logic signed [95:0] mix(logic signed [95:0] a, logic signed [95:0] b,
                                         longint w);
            logic signed [95:0] ww;
            ww = w;
            return a * (96'sd65536 - ww) + b * ww;
        endfunction

        function logic signed [95:0] round_down(logic signed [95:0] s, int k);
            return (s + (96'sd1 <<< (k - 1))) >>> k;
        endfunction

        function logic signed [95:0] corner(int x, int y, int z);
            return $signed(grid[x + NPTS * (y + NPTS * z)]);
        endfunction

        function void note_input(logic cmd, logic [3:0] ix, logic [3:0] iy, logic [3:0] iz,
                                 logic [31:0] val, logic [31:0] px, logic [31:0] py,
                                 logic [31:0] pz);
            int x0, y0, z0;
            longint wx, wy, wz;
            logic signed [95:0] c00, c10, c01, c11, c0, c1, r;
            if (cmd == tvi_pkg::CMD_WRITE) begin
                grid[ix + NPTS * (iy + NPTS * iz)] = val;
                return;
            end
            grid_coord(0, px, x0, wx);
            grid_coord(1, py, y0, wy);
            grid_coord(2, pz, z0, wz);
            c00 = mix(corner(x0, y0, z0), corner(x0 + 1, y0, z0), wx);
            c10 = mix(corner(x0, y0 + 1, z0), corner(x0 + 1, y0 + 1, z0), wx);
            c01 = mix(corner(x0, y0, z0 + 1), corner(x0 + 1, y0, z0 + 1), wx);
            c11 = mix(corner(x0, y0 + 1, z0 + 1), corner(x0 + 1, y0 + 1, z0 + 1), wx);
            c0 = round_down(mix(c00, c10, wy), 16);
            c1 = round_down(mix(c01, c11, wy), 16);
            r = round_down(mix(c0, c1, wz), 32);
            if (r > 96'sh7FFF_FFFF)
                r = 96'sh7FFF_FFFF;
            if (r < -96'sh8000_0000)
                r = -96'sh8000_0000;
            expected_values.insert(expected_values.size(), r[31:0]);
        endfunction

        function void check(logic [31:0] got);
            logic [31:0] want;
            if (expected_values.size() == 0) begin
                $error("interp_value: unexpected result %h", got);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (got !== want) begin
                $error("interp_value: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic [3:0]  i_write_ix;
    logic [3:0]  i_write_iy;
    logic [3:0]  i_write_iz;
    logic [31:0] i_write_value;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_interp_value;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    interp_scoreboard sb;
    bit written [NPTS*NPTS*NPTS];
    bit quiet;
    int hold_cycles;
    int idle_cycles;
    int items_sent;

    trilinear_volume_interpolator_top dut (.*);

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        i_stall <= 1'b0;
        hold_cycles = 0;
        quiet = 0;
        repeat (9) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b0) begin
                i_stall <= 1'b0;
            end else if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                hold_cycles = $urandom_range(0, 18);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check(o_interp_value);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("trilinear_volume_interpolator_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic cmd, logic [3:0] ix, logic [3:0] iy, logic [3:0] iz,
                             logic [31:0] val, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_write_ix    <= ix;
        i_write_iy    <= iy;
        i_write_iz    <= iz;
        i_write_value <= val;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_pos_z       <= pz;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, ix, iy, iz, val, px, py, pz);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_write(int x, int y, int z, logic [31:0] val);
        written[x + NPTS * (y + NPTS * z)] = 1;
        send_item(tvi_pkg::CMD_WRITE, 4'(x), 4'(y), 4'(z), val, $urandom, $urandom, $urandom);
    endtask

    // Any corner of the target cell that was never written gets a sample first.
    task automatic send_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int cx, cy, cz;
        longint w;
        sb.grid_coord(0, px, cx, w);
        sb.grid_coord(1, py, cy, w);
        sb.grid_coord(2, pz, cz, w);
        for (int k = 0; k < 8; k++) begin
            if (!written[(cx + k[0]) + NPTS * ((cy + k[1]) + NPTS * (cz + k[2]))])
                send_write(cx + k[0], cy + k[1], cz + k[2], rand_value());
        end
        send_item(tvi_pkg::CMD_QUERY, 4'($urandom), 4'($urandom), 4'($urandom), $urandom,
                  px, py, pz);
    endtask

    function automatic logic [31:0] rand_pos(int a);
        logic [63:0] span;
        if (sb.inv[a] == 0)
            span = 64'h10_0000;
        else
            span = (64'(NPTS + 1) << 32) / sb.inv[a];
        if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return sb.org[a] - 1;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return sb.org[a] + $urandom_range(0, int'(span[31:0]));
        endcase
    endfunction

    task automatic write_reg(tvi_pkg::t_cfg_idx idx, logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_inv();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return tvi_pkg::ONE_Q16;
            3: return $urandom_range(32'h1000, 32'h4_0000);
            default: return $urandom_range(32'h4000, 32'h20_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int phase_end;
        sb = new();
        items_sent = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= tvi_pkg::CMD_WRITE;
        i_write_ix <= '0;
        i_write_iy <= '0;
        i_write_iz <= '0;
        i_write_value <= '0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_pos_z <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= tvi_pkg::CFG_ORIGIN_X;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(tvi_pkg::CFG_ORIGIN_X, 32'h0);
        write_reg(tvi_pkg::CFG_ORIGIN_Y, 32'h0);
        write_reg(tvi_pkg::CFG_ORIGIN_Z, 32'h0);
        write_reg(tvi_pkg::CFG_INV_X, tvi_pkg::ONE_Q16);
        write_reg(tvi_pkg::CFG_INV_Y, tvi_pkg::ONE_Q16);
        write_reg(tvi_pkg::CFG_INV_Z, tvi_pkg::ONE_Q16);
        send_write(0, 0, 0, 32'h7FFF_FFFF);
        send_write(15, 15, 15, 32'h8000_0000);
        send_write(1, 0, 0, 32'h8000_0000);
        send_write(0, 1, 0, 32'h7FFF_FFFF);
        send_query(32'h0, 32'h0, 32'h0);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_query(32'h000F_0000, 32'h000E_FFFF, 32'h0001_0000);
        send_query(32'h0000_7FFF, 32'hFFFF_FFFF, 32'h000E_8000);
        drain();
        write_reg(tvi_pkg::CFG_INV_X, 32'h0);
        write_reg(tvi_pkg::CFG_INV_Y, 32'hFFFF_FFFF);
        write_reg(tvi_pkg::CFG_ORIGIN_Z, 32'h8000_0000);
        send_query(32'h0050_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_query(32'h1234_5678, 32'h0000_0002, 32'h8000_1000);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            if (ph == 5)
                quiet = 1;
            write_reg(tvi_pkg::CFG_ORIGIN_X, rand_origin());
            write_reg(tvi_pkg::CFG_ORIGIN_Y, rand_origin());
            write_reg(tvi_pkg::CFG_ORIGIN_Z, rand_origin());
            write_reg(tvi_pkg::CFG_INV_X, rand_inv());
            write_reg(tvi_pkg::CFG_INV_Y, rand_inv());
            write_reg(tvi_pkg::CFG_INV_Z, rand_inv());
            if (ph == 2)
                hold_cycles = 300;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 3)
                    send_write($urandom_range(0, NPTS - 1), $urandom_range(0, NPTS - 1),
                               $urandom_range(0, NPTS - 1), rand_value());
                else
                    send_query(rand_pos(0), rand_pos(1), rand_pos(2));
            end
        end
        drain();
        if (sb.errors == 0)
            $display("trilinear_volume_interpolator_top regression: pass");
        else
            $display("trilinear_volume_interpolator_top regression: fail");
        $finish;
    end

endmodule
